/* rtl/core/ksa_pkg.sv */
// Shared types, constants and helpers of the keyed session aggregator.
package ksa_pkg;

  // Table sizes.
  localparam int unsigned MAP_SLOTS   = 1024;
  localparam int unsigned MAX_ENTRIES = 1024;
  localparam int unsigned MAP_AW      = $clog2(MAP_SLOTS);
  localparam int unsigned ENT_AW      = $clog2(MAX_ENTRIES);

  // Clear sweep covers the larger of the two tables.
  localparam int unsigned CLR_DEPTH = (MAP_SLOTS > MAX_ENTRIES) ? MAP_SLOTS : MAX_ENTRIES;
  localparam int unsigned CLR_W     = $clog2(CLR_DEPTH);

  // Field widths fixed by the interface.
  localparam int unsigned IDX_W       = 10;
  localparam int unsigned ENTRY_CNT_W = 11;
  localparam int unsigned CFG_IDX_W   = 2;

  // Item modes.
  typedef enum logic [2:0] {
    MODE_MAP       = 3'd0,
    MODE_CLR_MAP   = 3'd1,
    MODE_CLR_STATS = 3'd2,
    MODE_SESSION   = 3'd3,
    MODE_READ      = 3'd4
  } mode_e;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PERIOD_START = 2'd0,
    CFG_PERIOD_END   = 2'd1,
    CFG_ENTRY_COUNT  = 2'd2
  } cfg_idx_e;

  // Controller states.
  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_LOOK,
    ST_UPD,
    ST_CLEAR
  } state_e;

  // Input transaction.
  typedef struct packed {
    logic [2:0]       mode;
    logic [31:0]      group_key;
    logic [IDX_W-1:0] entry_index;
    logic [31:0]      start_time;
    logic [31:0]      span;
    logic             final_session;
  } req_t;

  // Result transaction.
  typedef struct packed {
    logic             hit;
    logic [IDX_W-1:0] result_index;
    logic [31:0]      total_time;
    logic [31:0]      session_tally;
    logic [31:0]      latest_end;
    logic [31:0]      window_time;
    logic             pass_done;
  } rsp_t;

  // One key map slot.
  typedef struct packed {
    logic             valid;
    logic [IDX_W-1:0] idx;
  } map_slot_t;

  // One statistics entry.
  typedef struct packed {
    logic [31:0] total;
    logic [31:0] tally;
    logic [31:0] latest;
    logic [31:0] window;
  } stat_t;

  // Key map port controls.
  typedef struct packed {
    logic              rd_en;
    logic [MAP_AW-1:0] rd_addr;
    logic              wr_en;
    logic [MAP_AW-1:0] wr_addr;
    map_slot_t         wr_data;
  } map_ctl_t;

  // Statistics store port controls.
  typedef struct packed {
    logic              rd_en;
    logic [ENT_AW-1:0] rd_addr;
    logic              upd_en;
    logic              clr_en;
    logic [ENT_AW-1:0] clr_addr;
  } stat_ctl_t;

  // An entry index is usable when below both the configured count and the table size.
  function automatic logic entry_ok(logic [IDX_W-1:0] idx, logic [ENTRY_CNT_W-1:0] cnt);
    entry_ok = (32'(idx) < 32'(cnt)) && (32'(idx) < 32'(MAX_ENTRIES));
  endfunction

endpackage

/* rtl/core/ksa_key_map.sv */
// Key map memory: one slot per key, each a valid bit and an entry index.
module ksa_key_map import ksa_pkg::*; (
  input  logic      clk_i,
  input  map_ctl_t  ctl_i,
  output map_slot_t slot_o
);

  map_slot_t mem [MAP_SLOTS];
  map_slot_t rd_q;

  // Single write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      mem[ctl_i.wr_addr] <= ctl_i.wr_data;
    end
    if (ctl_i.rd_en) begin
      rd_q <= mem[ctl_i.rd_addr];
    end
  end

  assign slot_o = rd_q;

endmodule

/* rtl/core/ksa_stat_store.sv */
// Statistics memory with the read-modify-write update of one session.
module ksa_stat_store import ksa_pkg::*; (
  input  logic        clk_i,
  input  stat_ctl_t   ctl_i,
  input  logic        is_session_i,
  input  logic [31:0] start_time_i,
  input  logic [31:0] span_i,
  input  logic [31:0] period_start_i,
  input  logic [31:0] period_end_i,
  output stat_t       stat_o
);

  stat_t             mem [MAX_ENTRIES];
  stat_t             rd_q;
  logic [ENT_AW-1:0] upd_addr_q;
  stat_t             new_stat;
  logic [31:0]       end_time;
  logic              in_window;

  // Updated entry for a session, computed from the read data.
  always_comb begin
    end_time      = start_time_i + span_i;
    in_window     = (start_time_i >= period_start_i) && (start_time_i <= period_end_i);
    new_stat.total  = rd_q.total + span_i;
    new_stat.tally  = rd_q.tally + 32'd1;
    new_stat.latest = (end_time > rd_q.latest) ? end_time : rd_q.latest;
    new_stat.window = in_window ? (rd_q.window + span_i) : rd_q.window;
  end

  assign stat_o = is_session_i ? new_stat : rd_q;

  // Clear sweep writes take the port ahead of updates; they never coincide.
  always_ff @(posedge clk_i) begin
    if (ctl_i.clr_en) begin
      mem[ctl_i.clr_addr] <= '0;
    end else if (ctl_i.upd_en) begin
      mem[upd_addr_q] <= new_stat;
    end
    if (ctl_i.rd_en) begin
      rd_q       <= mem[ctl_i.rd_addr];
      upd_addr_q <= ctl_i.rd_addr;
    end
  end

endmodule

/* rtl/core/keyed_session_aggregator.sv */
// Top level of the keyed session aggregator: controller, configuration and result register.
//
// Usage. Items arrive on req_i and are taken at a clock edge where start is high and
// busy is low. Each item gives exactly one result on rsp_o, shown for one cycle with
// done_o high; the receiver cannot hold it off.
// Map, session, read and unused modes pass from acceptance to result through a key map
// read, a statistics read, then the update and write back. done_o rises the cycle after
// the write, and a new item may be accepted in that same cycle.
// Clear map and clear stats sweep the tables one entry a cycle, since the single write
// port of each memory sets the pace.
// Configuration is written on cfg_valid_i/cfg_index_i/cfg_data_i; cfg_ready_o is always
// high. Registers are period_start (0), period_end (1) and entry_count (2); other
// indexes are ignored. Write configuration only while no transaction is in flight.
// After reset the block runs a clearing pass over the key map and the statistics store
// with busy high; configuration writes are taken during that pass.
module keyed_session_aggregator import ksa_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  req_t                 req_i,
  output logic                 done_o,
  output rsp_t                 rsp_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [31:0]          cfg_data_i
);

  state_e                 state_q, state_d;
  logic [CLR_W-1:0]       clr_q, clr_d;
  logic                   clr_last;
  req_t                   req_q;
  logic                   hit_q, hit_d;
  logic [IDX_W-1:0]       idx_q, idx_d;
  logic                   done_q, done_d;
  rsp_t                   rsp_q, rsp_d;
  logic [31:0]            period_start_q;
  logic [31:0]            period_end_q;
  logic [ENTRY_CNT_W-1:0] entry_count_q;
  logic                   key_ok;
  logic                   is_session;
  logic                   slot_hit;
  map_ctl_t               map_ctl;
  map_slot_t              slot;
  stat_ctl_t              stat_ctl;
  stat_t                  stat;

  // Memories.
  ksa_key_map u_key_map (
    .clk_i  (clk_i),
    .ctl_i  (map_ctl),
    .slot_o (slot)
  );

  ksa_stat_store u_stat_store (
    .clk_i          (clk_i),
    .ctl_i          (stat_ctl),
    .is_session_i   (is_session),
    .start_time_i   (req_q.start_time),
    .span_i         (req_q.span),
    .period_start_i (period_start_q),
    .period_end_i   (period_end_q),
    .stat_o         (stat)
  );

  // Configuration registers.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_start_q <= '0;
      period_end_q   <= '1;
      entry_count_q  <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_PERIOD_START: period_start_q <= cfg_data_i;
        CFG_PERIOD_END:   period_end_q   <= cfg_data_i;
        CFG_ENTRY_COUNT:  entry_count_q  <= cfg_data_i[ENTRY_CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Decode of the held transaction.
  assign key_ok     = req_q.group_key < 32'(MAP_SLOTS);
  assign is_session = req_q.mode == MODE_SESSION;
  assign clr_last   = clr_q == CLR_W'(CLR_DEPTH - 1);

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_INIT: begin
        if (clr_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (start) begin
          if (req_i.mode inside {MODE_CLR_MAP, MODE_CLR_STATS}) begin
            state_d = ST_CLEAR;
          end else begin
            state_d = ST_LOOK;
          end
        end
      end
      ST_LOOK:  state_d = ST_UPD;
      ST_UPD:   state_d = ST_IDLE;
      ST_CLEAR: begin
        if (clr_last) state_d = ST_IDLE;
      end
      default:  state_d = ST_INIT;
    endcase
  end

  // Outputs and memory controls.
  always_comb begin
    busy     = 1'b1;
    map_ctl  = '0;
    stat_ctl = '0;
    slot_hit = 1'b0;
    hit_d    = hit_q;
    idx_d    = idx_q;
    done_d   = 1'b0;
    rsp_d    = rsp_q;
    case (state_q)
      ST_INIT: begin
        map_ctl.wr_en     = 32'(clr_q) < 32'(MAP_SLOTS);
        map_ctl.wr_addr   = clr_q[MAP_AW-1:0];
        stat_ctl.clr_en   = 32'(clr_q) < 32'(MAX_ENTRIES);
        stat_ctl.clr_addr = clr_q[ENT_AW-1:0];
      end
      ST_IDLE: begin
        busy            = 1'b0;
        map_ctl.rd_en   = start;
        map_ctl.rd_addr = req_i.group_key[MAP_AW-1:0];
      end
      ST_LOOK: begin
        // Resolve the entry and start its statistics read.
        map_ctl.wr_en         = (req_q.mode == MODE_MAP) && key_ok;
        map_ctl.wr_addr       = req_q.group_key[MAP_AW-1:0];
        map_ctl.wr_data.valid = 1'b1;
        map_ctl.wr_data.idx   = req_q.entry_index;
        if (req_q.mode == MODE_READ) begin
          idx_d    = req_q.entry_index;
          slot_hit = 1'b1;
        end else begin
          idx_d    = slot.idx;
          slot_hit = is_session && key_ok && slot.valid;
        end
        hit_d            = slot_hit && entry_ok(idx_d, entry_count_q);
        stat_ctl.rd_en   = 1'b1;
        stat_ctl.rd_addr = idx_d[ENT_AW-1:0];
      end
      ST_UPD: begin
        // Write back a session update and form the result.
        stat_ctl.upd_en = hit_q && is_session;
        done_d          = 1'b1;
        rsp_d           = '0;
        if (hit_q) begin
          rsp_d.hit           = 1'b1;
          rsp_d.result_index  = idx_q;
          rsp_d.total_time    = stat.total;
          rsp_d.session_tally = stat.tally;
          rsp_d.latest_end    = stat.latest;
          rsp_d.window_time   = stat.window;
        end
        rsp_d.pass_done = is_session && req_q.final_session;
      end
      ST_CLEAR: begin
        map_ctl.wr_en     = (req_q.mode == MODE_CLR_MAP) && (32'(clr_q) < 32'(MAP_SLOTS));
        map_ctl.wr_addr   = clr_q[MAP_AW-1:0];
        stat_ctl.clr_en   = (req_q.mode == MODE_CLR_STATS) &&
                            (32'(clr_q) < 32'(MAX_ENTRIES));
        stat_ctl.clr_addr = clr_q[ENT_AW-1:0];
        if (clr_last) begin
          done_d = 1'b1;
          rsp_d  = '0;
        end
      end
      default: ;
    endcase
  end

  // Sweep counter runs only while clearing.
  always_comb begin
    if ((state_q == ST_INIT) || (state_q == ST_CLEAR)) begin
      clr_d = clr_q + CLR_W'(1);
    end else begin
      clr_d = '0;
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
      clr_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      done_q  <= done_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      req_q <= req_i;
    end
    hit_q <= hit_d;
    idx_q <= idx_d;
    rsp_q <= rsp_d;
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  // An accepted transaction keeps the block busy in the next cycle.
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("block not busy after accepting a transaction");

  // The update stage always delivers its result in the following cycle.
  a_upd_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_UPD) |=> done_o)
    else $error("update stage did not deliver a result");

  // No memory write happens while the block is idle.
  a_idle_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> (!map_ctl.wr_en && !stat_ctl.clr_en && !stat_ctl.upd_en))
    else $error("memory write while idle");

  // Results are single-cycle pulses.
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe held for more than one cycle");

endmodule

/* verif/testbench.sv */
// Self-checking testbench for the keyed session aggregator with an in-line table predictor.
module testbench;
  import ksa_pkg::*;

  // Configuration index with no register behind it; writes to it must change nothing.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
  // Mode codes with no operation behind them.
  localparam logic [2:0] MODE_SPARE_LO = 3'd5;
  localparam logic [2:0] MODE_SPARE_HI = 3'd7;
  // Random stimulus shaping.
  localparam int unsigned POOL_KEYS   = 12;
  localparam int unsigned HOT_ENTRIES = 32;
  localparam int unsigned RUN_LIMIT   = 1000000;

  // Mirror of the aggregation table: predicts each result and checks the block against it.
  class session_table_board;
    bit               slot_full[MAP_SLOTS];
    logic [IDX_W-1:0] slot_idx[MAP_SLOTS];
    logic [31:0]      sum_span[MAX_ENTRIES];
    logic [31:0]      session_cnt[MAX_ENTRIES];
    logic [31:0]      last_end[MAX_ENTRIES];
    logic [31:0]      win_span[MAX_ENTRIES];
    logic [31:0]      win_lo;
    logic [31:0]      win_hi;
    logic [10:0]      live_count;
    rsp_t             awaited_rows[$];
    int unsigned      mismatches;

    function new();
      slot_full   = '{default: 1'b0};
      slot_idx    = '{default: '0};
      win_lo      = '0;
      win_hi      = '1;
      live_count  = '0;
      mismatches  = 0;
      wipe_stats();
    endfunction

    function void wipe_stats();
      sum_span    = '{default: '0};
      session_cnt = '{default: '0};
      last_end    = '{default: '0};
      win_span    = '{default: '0};
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] which, logic [31:0] value);
      case (which)
        CFG_PERIOD_START: win_lo = value;
        CFG_PERIOD_END:   win_hi = value;
        CFG_ENTRY_COUNT:  live_count = value[10:0];
        default: ;
      endcase
    endfunction

    // An entry counts only below both the configured count and the table size.
    function bit entry_live(logic [IDX_W-1:0] idx);
      return ({1'b0, idx} < live_count) && (int'(idx) < MAX_ENTRIES);
    endfunction

    function rsp_t entry_view(logic [IDX_W-1:0] idx, logic fin);
      rsp_t row;
      row.hit           = 1'b1;
      row.result_index  = idx;
      row.total_time    = sum_span[idx];
      row.session_tally = session_cnt[idx];
      row.latest_end    = last_end[idx];
      row.window_time   = win_span[idx];
      row.pass_done     = fin;
      return row;
    endfunction

    // Applies one accepted transaction to the mirror and queues the result it must give.
    function void take_item(req_t it);
      rsp_t             row;
      logic [IDX_W-1:0] slot;
      logic [31:0]      finish_at;
      row = '0;
      case (it.mode)
        MODE_MAP: begin
          if (it.group_key < MAP_SLOTS) begin
            slot_full[it.group_key[MAP_AW-1:0]] = 1'b1;
            slot_idx[it.group_key[MAP_AW-1:0]]  = it.entry_index;
          end
        end
        MODE_CLR_MAP: slot_full = '{default: 1'b0};
        MODE_CLR_STATS: wipe_stats();
        MODE_SESSION: begin
          row.pass_done = it.final_session;
          if (it.group_key < MAP_SLOTS && slot_full[it.group_key[MAP_AW-1:0]]) begin
            slot = slot_idx[it.group_key[MAP_AW-1:0]];
            if (entry_live(slot)) begin
              finish_at          = it.start_time + it.span;
              sum_span[slot]    += it.span;
              session_cnt[slot] += 32'd1;
              if (finish_at > last_end[slot]) last_end[slot] = finish_at;
              if (it.start_time >= win_lo && it.start_time <= win_hi) begin
                win_span[slot] += it.span;
              end
              row = entry_view(slot, it.final_session);
            end
          end
        end
        MODE_READ: begin
          if (entry_live(it.entry_index)) row = entry_view(it.entry_index, 1'b0);
        end
        default: ;
      endcase
      awaited_rows.push_back(row);
    endfunction

    function void diff(string field, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $error("%s: expected 0x%0h, actual 0x%0h", field, want, got);
        mismatches++;
      end
    endfunction

    // Compares one result transaction with the oldest prediction.
    function void match_result(rsp_t got);
      rsp_t want;
      if (awaited_rows.size() == 0) begin
        $error("result 0x%0h arrived with no prediction waiting", got);
        mismatches++;
        return;
      end
      want = awaited_rows.pop_front();
      diff("hit", 32'(want.hit), 32'(got.hit));
      diff("result_index", 32'(want.result_index), 32'(got.result_index));
      diff("total_time", want.total_time, got.total_time);
      diff("session_tally", want.session_tally, got.session_tally);
      diff("latest_end", want.latest_end, got.latest_end);
      diff("window_time", want.window_time, got.window_time);
      diff("pass_done", 32'(want.pass_done), 32'(got.pass_done));
    endfunction

    function int unsigned waiting();
      return awaited_rows.size();
    endfunction

    function bit all_clean();
      if (awaited_rows.size() != 0) begin
        $error("%0d predicted results never arrived", awaited_rows.size());
        mismatches++;
      end
      return mismatches == 0;
    endfunction
  endclass

  logic                 clk_i     = 1'b0;
  logic                 rst_ni    = 1'b0;
  logic                 start     = 1'b0;
  logic                 busy;
  req_t                 req       = '0;
  logic                 done_o;
  rsp_t                 rsp;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0]          cfg_data  = '0;

  session_table_board board = new();

  // Settings the stimulus is currently shaped for.
  logic [31:0] cur_lo;
  logic [31:0] cur_hi;
  int unsigned cur_count;
  int unsigned clear_budget = 30;
  logic [31:0] pool[POOL_KEYS];

  keyed_session_aggregator dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .req_i       (req),
    .done_o      (done_o),
    .rsp_o       (rsp),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Every strobed result is taken at the edge that ends its cycle.
  always @(posedge clk_i) begin
    if (rst_ni && done_o) board.match_result(rsp);
  end

  // Hands one transaction to the block, optionally after a random idle burst.
  task automatic push_item(input req_t it, input bit may_idle);
    if (may_idle && $urandom_range(4, 0) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(9, 1)) @(posedge clk_i);
    end
    req   <= it;
    start <= 1'b1;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    board.take_item(it);
  endtask

  // Stops sending and waits until every predicted result has come back.
  task automatic settle();
    start <= 1'b0;
    while (board.waiting() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] which, input logic [31:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= which;
    cfg_data  <= value;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    board.set_reg(which, value);
  endtask

  task automatic load_setting(input logic [31:0] lo, input logic [31:0] hi,
                              input int unsigned cnt);
    write_reg(CFG_PERIOD_START, lo);
    write_reg(CFG_PERIOD_END, hi);
    write_reg(CFG_ENTRY_COUNT, 32'(cnt));
    cfg_valid <= 1'b0;
    cur_lo    = lo;
    cur_hi    = hi;
    cur_count = cnt;
  endtask

  function automatic req_t item_of(logic [2:0] mode, logic [31:0] key, logic [IDX_W-1:0] idx,
                                   logic [31:0] st, logic [31:0] sp, logic fin);
    req_t it;
    it.mode          = mode;
    it.group_key     = key;
    it.entry_index   = idx;
    it.start_time    = st;
    it.span          = sp;
    it.final_session = fin;
    return it;
  endfunction

  // Mostly sessions on a small pool of mapped keys, with map, read, clear and noise mixed in.
  function automatic req_t rand_item();
    req_t        it;
    int unsigned pick;
    int unsigned hot;
    it.mode          = MODE_SESSION;
    it.group_key     = $urandom;
    it.entry_index   = IDX_W'($urandom);
    it.start_time    = $urandom;
    it.span          = $urandom;
    it.final_session = 1'($urandom);
    hot  = (cur_count == 0) ? 1 : ((cur_count < HOT_ENTRIES) ? cur_count : HOT_ENTRIES);
    pick = $urandom_range(999, 0);
    if (pick < 100) begin
      it.mode = MODE_MAP;
      if (pick < 90) it.group_key = pool[$urandom_range(POOL_KEYS - 1, 0)];
      else if (pick < 95) it.group_key = $urandom_range(MAP_SLOTS - 1, 0);
      if (pick < 80) it.entry_index = IDX_W'($urandom_range(hot - 1, 0));
    end else if (pick < 160) begin
      if (pick < 112 && clear_budget > 0) begin
        it.mode = (pick < 106) ? MODE_CLR_MAP : MODE_CLR_STATS;
        clear_budget--;
      end else begin
        it.mode = 3'($urandom_range(MODE_SPARE_HI, MODE_SPARE_LO));
      end
    end else if (pick < 800) begin
      if (pick < 700) it.group_key = pool[$urandom_range(POOL_KEYS - 1, 0)];
      else if (pick < 750) it.group_key = $urandom_range(MAP_SLOTS - 1, 0);
      // Aim start times inside the window and at its edges.
      case ($urandom_range(3, 0))
        0: it.start_time = $urandom_range(cur_hi, cur_lo);
        1: begin
          case ($urandom_range(3, 0))
            0: it.start_time = cur_lo;
            1: it.start_time = cur_hi;
            2: it.start_time = cur_lo - 32'd1;
            default: it.start_time = cur_hi + 32'd1;
          endcase
        end
        default: ;
      endcase
      if ($urandom_range(1, 0) != 0) it.span = $urandom_range(5000, 0);
    end else begin
      it.mode = MODE_READ;
      if (pick < 950) it.entry_index = IDX_W'($urandom_range(hot - 1, 0));
    end
    return it;
  endfunction

  task automatic run_random(input int unsigned count, input bit may_idle);
    repeat (count) push_item(rand_item(), may_idle);
  endtask

  // Main sequence: directed corner cases, then random phases under varied settings.
  initial begin
    logic [31:0] lo;
    logic [31:0] hi;
    logic [31:0] tmp;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    load_setting(32'h0, 32'hFFFF_FFFF, MAX_ENTRIES);

    // Directed: extremes of keys and indexes, wrap-around, misses, clears, unused modes.
    push_item(item_of(MODE_READ, 32'h0, 10'd0, 32'h0, 32'h0, 1'b0), 1'b0);
    push_item(item_of(MODE_READ, 32'h0, 10'h3FF, 32'h0, 32'h0, 1'b0), 1'b0);
    push_item(item_of(MODE_SESSION, 32'd5, 10'd0, 32'd10, 32'd20, 1'b1), 1'b0);
    push_item(item_of(MODE_MAP, 32'h0, 10'd0, 32'h0, 32'h0, 1'b0), 1'b0);
    push_item(item_of(MODE_MAP, 32'(MAP_SLOTS - 1), 10'h3FF, 32'h0, 32'h0, 1'b0), 1'b0);
    push_item(item_of(MODE_MAP, 32'(MAP_SLOTS), 10'd7, 32'h0, 32'h0, 1'b0), 1'b0);
    push_item(item_of(MODE_MAP, 32'hFFFF_FFFF, 10'h3FF, '1, '1, 1'b1), 1'b0);
    push_item(item_of(MODE_MAP, 32'd2, 10'h3FF, 32'h0, 32'h0, 1'b0), 1'b0);
    push_item(item_of(MODE_SESSION, 32'h0, 10'h3FF, '1, '1, 1'b1), 1'b0);
    push_item(item_of(MODE_SESSION, 32'h0, 10'd0, 32'h0, 32'd1, 1'b0), 1'b0);
    push_item(item_of(MODE_SESSION, 32'(MAP_SLOTS - 1), 10'd0, 32'h0, '1, 1'b1), 1'b0);
    push_item(item_of(MODE_SESSION, 32'd2, 10'd0, 32'h8000_0000, 32'h8000_0000, 1'b0), 1'b0);
    push_item(item_of(MODE_SESSION, 32'(MAP_SLOTS), 10'd0, 32'd1, 32'd1, 1'b1), 1'b0);
    push_item(item_of(MODE_SESSION, 32'hFFFF_FFFF, 10'h3FF, '1, '1, 1'b1), 1'b0);
    push_item(item_of(MODE_READ, 32'h0, 10'd0, 32'h0, 32'h0, 1'b1), 1'b0);
    push_item(item_of(MODE_READ, '1, 10'h3FF, '1, '1, 1'b1), 1'b0);
    push_item(item_of(MODE_SPARE_LO, '1, 10'h3FF, '1, '1, 1'b1), 1'b0);
    push_item(item_of(MODE_SPARE_LO + 3'd1, 32'h0, 10'd0, 32'h0, 32'h0, 1'b0), 1'b0);
    push_item(item_of(MODE_SPARE_HI, '1, 10'h3FF, '1, '1, 1'b1), 1'b0);
    push_item(item_of(MODE_CLR_STATS, '1, 10'h3FF, '1, '1, 1'b1), 1'b0);
    push_item(item_of(MODE_READ, 32'h0, 10'd0, 32'h0, 32'h0, 1'b0), 1'b0);
    push_item(item_of(MODE_SESSION, 32'h0, 10'd0, 32'd100, 32'd50, 1'b1), 1'b0);
    push_item(item_of(MODE_CLR_MAP, '1, 10'h3FF, '1, '1, 1'b1), 1'b0);
    push_item(item_of(MODE_SESSION, 32'h0, 10'd0, 32'd100, 32'd50, 1'b0), 1'b0);
    push_item(item_of(MODE_READ, 32'h0, 10'h3FF, 32'h0, 32'h0, 1'b0), 1'b0);
    settle();

    foreach (pool[i]) pool[i] = $urandom_range(MAP_SLOTS - 1, 0);

    // Unmapped register index, then a small table with an arbitrary window.
    write_reg(CFG_SPARE, $urandom);
    load_setting($urandom, $urandom, 16);
    run_random(300, 1'b1);
    settle();

    load_setting('1, '1, MAX_ENTRIES);
    run_random(300, 1'b1);
    settle();

    // No entries in use: every lookup misses.
    lo = $urandom;
    hi = $urandom;
    if (lo > hi) begin
      tmp = lo;
      lo  = hi;
      hi  = tmp;
    end
    load_setting(lo, hi, 0);
    run_random(60, 1'b1);
    settle();

    load_setting(32'h0, 32'h0, 1);
    run_random(250, 1'b1);
    settle();

    lo = $urandom;
    hi = $urandom;
    if (lo > hi) begin
      tmp = lo;
      lo  = hi;
      hi  = tmp;
    end
    load_setting(lo, hi, $urandom_range(MAX_ENTRIES - 1, 2));
    run_random(350, 1'b1);
    settle();

    // Empty window, sent back to back to the end.
    load_setting('1, 32'h0, 1000);
    run_random(365, 1'b0);
    settle();
    repeat (8) @(posedge clk_i);

    if (board.all_clean()) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #(RUN_LIMIT);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

/* filelist.f */
rtl/core/ksa_pkg.sv
rtl/core/ksa_key_map.sv
rtl/core/ksa_stat_store.sv
rtl/core/keyed_session_aggregator.sv
verif/testbench.sv
